FILE: rtl/core/mwm_pkg.sv
package mwm_pkg;

  localparam int SPEED_WIDTH   = 16;
  localparam int FRACTION_BITS = 12;

  localparam int LANES  = 4;
  localparam int LIM_W  = SPEED_WIDTH - 1;
  localparam int SUM_W  = SPEED_WIDTH + 2;
  localparam int MAG_W  = SPEED_WIDTH + 1;
  localparam int QUO_W  = LIM_W;
  localparam int PROD_W = MAG_W + LIM_W;

  localparam int WHEEL_FL = 0;
  localparam int WHEEL_FR = 1;
  localparam int WHEEL_BL = 2;
  localparam int WHEEL_BR = 3;

  typedef logic signed [SPEED_WIDTH-1:0] speed_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic [LIM_W-1:0]              lim_t;
  typedef logic [MAG_W-1:0]              mag_t;
  typedef logic [PROD_W-1:0]             prod_t;

  // 1.5 in the configured fixed point format, cut to the register width.
  localparam lim_t SPEED_LIMIT_RESET = LIM_W'(64'd3 << (FRACTION_BITS - 1));

  typedef struct packed {
    logic                          scale;
    logic [LANES-1:0]              neg;
    logic [LANES-1:0][SPEED_WIDTH-1:0] raw;
  } wheel_tag_t;

  typedef struct packed {
    prod_t [LANES-1:0] prod;
    mag_t              divisor;
    wheel_tag_t        tag;
  } div_in_t;

  typedef struct packed {
    lim_t [LANES-1:0] quo;
    wheel_tag_t       tag;
  } div_out_t;

  function automatic logic [SPEED_WIDTH-1:0] speed_abs(input speed_t s);
    logic [SPEED_WIDTH-1:0] u;
    u = s;
    return s[SPEED_WIDTH-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

FILE: rtl/core/mwm_cmd_if.sv
interface mwm_cmd_if import mwm_pkg::*; ();
  logic   valid;
  logic   ready;
  speed_t vel_forward;
  speed_t vel_sideways;
  speed_t vel_rotation;

  modport source (output valid, output vel_forward, output vel_sideways,
                  output vel_rotation, input ready);
  modport sink   (input valid, input vel_forward, input vel_sideways,
                  input vel_rotation, output ready);
endinterface

FILE: rtl/core/mwm_wheel_if.sv
interface mwm_wheel_if import mwm_pkg::*; ();
  logic   valid;
  logic   ready;
  speed_t wheel_front_left;
  speed_t wheel_front_right;
  speed_t wheel_back_left;
  speed_t wheel_back_right;
  logic   was_scaled;

  modport source (output valid, output wheel_front_left, output wheel_front_right,
                  output wheel_back_left, output wheel_back_right,
                  output was_scaled, input ready);
  modport sink   (input valid, input wheel_front_left, input wheel_front_right,
                  input wheel_back_left, input wheel_back_right,
                  input was_scaled, output ready);
endinterface

FILE: rtl/core/mwm_cfg_if.sv
interface mwm_cfg_if import mwm_pkg::*; ();
  logic valid;
  logic ready;
  lim_t speed_limit;

  modport source (output valid, output speed_limit, input ready);
  modport sink   (input valid, input speed_limit, output ready);
endinterface

FILE: rtl/core/mwm_divider.sv
module mwm_divider import mwm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     up_valid_i,
  output logic     up_ready_o,
  input  div_in_t  up_data_i,
  output logic     down_valid_o,
  input  logic     down_ready_i,
  output div_out_t down_data_o
);

  logic [QUO_W:0]    valid_q;
  logic [QUO_W:0]    en;
  mag_t [LANES-1:0]  rem_q  [QUO_W+1];
  lim_t [LANES-1:0]  bits_q [QUO_W+1];
  mag_t              div_q  [QUO_W+1];
  wheel_tag_t        tag_q  [QUO_W+1];

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[QUO_W] = !valid_q[QUO_W] || down_ready_i;
    for (int k = QUO_W - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign up_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= up_valid_i;
      end
      for (int k = 1; k <= QUO_W; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // The quotient never reaches 2**QUO_W, so the top of the product is already
  // below the divisor and can serve as the starting remainder.
  always_ff @(posedge clk_i) begin
    if (en[0] && up_valid_i) begin
      for (int l = 0; l < LANES; l++) begin
        rem_q[0][l]  <= up_data_i.prod[l][PROD_W-1:QUO_W];
        bits_q[0][l] <= up_data_i.prod[l][QUO_W-1:0];
      end
      div_q[0] <= up_data_i.divisor;
      tag_q[0] <= up_data_i.tag;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    logic [LANES-1:0][MAG_W:0] trial;
    logic [LANES-1:0]          take;
    mag_t [LANES-1:0]          rem_d;
    lim_t [LANES-1:0]          bits_d;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l]  = {rem_q[k-1][l], bits_q[k-1][l][QUO_W-1]};
        take[l]   = trial[l] >= {1'b0, div_q[k-1]};
        rem_d[l]  = take[l] ? MAG_W'(trial[l] - {1'b0, div_q[k-1]})
                            : trial[l][MAG_W-1:0];
        bits_d[l] = {bits_q[k-1][l][QUO_W-2:0], take[l]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && valid_q[k-1]) begin
        rem_q[k]  <= rem_d;
        bits_q[k] <= bits_d;
        div_q[k]  <= div_q[k-1];
        tag_q[k]  <= tag_q[k-1];
      end
    end
  end

  assign down_valid_o    = valid_q[QUO_W];
  assign down_data_o.quo = bits_q[QUO_W];
  assign down_data_o.tag = tag_q[QUO_W];

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[QUO_W] && tag_q[QUO_W].scale |->
      (rem_q[QUO_W][WHEEL_FL] < div_q[QUO_W]) && (rem_q[QUO_W][WHEEL_FR] < div_q[QUO_W]) &&
      (rem_q[QUO_W][WHEEL_BL] < div_q[QUO_W]) && (rem_q[QUO_W][WHEEL_BR] < div_q[QUO_W]))
    else $error("divider remainder not below divisor");

endmodule

FILE: rtl/core/mecanum_wheel_mixer.sv
// Pipeline: an accepted command passes through three registers for the wheel
// sums, magnitudes and maximum, one for the products, fifteen in the
// divider (one quotient bit per stage) and one output register.
// Throughput: one command per cycle; a stalled output holds each full stage.
// Reset (asynchronous, active low) empties every stage and sets the speed limit
// to 1.5.
module mecanum_wheel_mixer import mwm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  mwm_cfg_if.sink     cfg_i,
  mwm_cmd_if.sink     cmd_i,
  mwm_wheel_if.source wheel_o
);

  lim_t limit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= SPEED_LIMIT_RESET;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.speed_limit;
    end
  end

  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, en_out;
  logic div_ready, div_valid;
  div_in_t  div_in;
  div_out_t div_out;

  assign en_out      = !vo_q || wheel_o.ready;
  assign en3         = !v3_q || div_ready;
  assign en2         = !v2_q || en3;
  assign en1         = !v1_q || en2;
  assign cmd_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1)    v1_q <= cmd_i.valid;
      if (en2)    v2_q <= v1_q;
      if (en3)    v3_q <= v2_q;
      if (en_out) vo_q <= div_valid;
    end
  end

  // Stage 1: wheel sums at full width.
  sum_t fx, fy, fw;
  sum_t [LANES-1:0] sum_d, sum_q;

  assign fx = SUM_W'(cmd_i.vel_forward);
  assign fy = SUM_W'(cmd_i.vel_sideways);
  assign fw = SUM_W'(cmd_i.vel_rotation);

  always_comb begin
    sum_d[WHEEL_FL] = fx - fy - fw;
    sum_d[WHEEL_FR] = fx + fy + fw;
    sum_d[WHEEL_BL] = fx + fy - fw;
    sum_d[WHEEL_BR] = fx - fy + fw;
  end

  always_ff @(posedge clk_i) begin
    if (en1 && cmd_i.valid) begin
      sum_q <= sum_d;
    end
  end

  // Stage 2: magnitudes and signs.
  mag_t [LANES-1:0] mag2_q;
  wheel_tag_t       tag2_q;

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      for (int l = 0; l < LANES; l++) begin
        mag2_q[l]     <= sum_q[l][SUM_W-1] ? MAG_W'(-sum_q[l]) : MAG_W'(sum_q[l]);
        tag2_q.neg[l] <= sum_q[l][SUM_W-1];
        tag2_q.raw[l] <= sum_q[l][SPEED_WIDTH-1:0];
      end
      tag2_q.scale <= 1'b0;
    end
  end

  // Stage 3: largest magnitude and the decision to scale.
  mag_t max_a, max_b, max_d;
  mag_t [LANES-1:0] mag3_q;
  mag_t             max3_q;
  wheel_tag_t       tag3_q;

  assign max_a = (mag2_q[WHEEL_FL] > mag2_q[WHEEL_FR]) ? mag2_q[WHEEL_FL] : mag2_q[WHEEL_FR];
  assign max_b = (mag2_q[WHEEL_BL] > mag2_q[WHEEL_BR]) ? mag2_q[WHEEL_BL] : mag2_q[WHEEL_BR];
  assign max_d = (max_a > max_b) ? max_a : max_b;

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      mag3_q       <= mag2_q;
      max3_q       <= max_d;
      tag3_q.neg   <= tag2_q.neg;
      tag3_q.raw   <= tag2_q.raw;
      tag3_q.scale <= max_d > MAG_W'(limit_q);
    end
  end

  // Products go straight into the first divider register.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      div_in.prod[l] = PROD_W'(mag3_q[l]) * PROD_W'(limit_q);
    end
    div_in.divisor = max3_q;
    div_in.tag     = tag3_q;
  end

  mwm_divider u_divider (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .up_valid_i   (v3_q),
    .up_ready_o   (div_ready),
    .up_data_i    (div_in),
    .down_valid_o (div_valid),
    .down_ready_i (en_out),
    .down_data_o  (div_out)
  );

  // Output register: signed quotient when scaling, otherwise the sum itself.
  speed_t [LANES-1:0] wheel_d, wheel_q;
  logic               scaled_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (div_out.tag.scale) begin
        wheel_d[l] = div_out.tag.neg[l] ? -SPEED_WIDTH'(div_out.quo[l])
                                        : SPEED_WIDTH'(div_out.quo[l]);
      end else begin
        wheel_d[l] = div_out.tag.raw[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out && div_valid) begin
      wheel_q  <= wheel_d;
      scaled_q <= div_out.tag.scale;
    end
  end

  assign wheel_o.valid             = vo_q;
  assign wheel_o.wheel_front_left  = wheel_q[WHEEL_FL];
  assign wheel_o.wheel_front_right = wheel_q[WHEEL_FR];
  assign wheel_o.wheel_back_left   = wheel_q[WHEEL_BL];
  assign wheel_o.wheel_back_right  = wheel_q[WHEEL_BR];
  assign wheel_o.was_scaled        = scaled_q;

  a_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |->
      (speed_abs(wheel_q[WHEEL_FL]) <= {1'b0, limit_q}) &&
      (speed_abs(wheel_q[WHEEL_FR]) <= {1'b0, limit_q}) &&
      (speed_abs(wheel_q[WHEEL_BL]) <= {1'b0, limit_q}) &&
      (speed_abs(wheel_q[WHEEL_BR]) <= {1'b0, limit_q}))
    else $error("wheel speed above the limit");

  a_scaled_hits_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && scaled_q |->
      (speed_abs(wheel_q[WHEEL_FL]) == {1'b0, limit_q}) ||
      (speed_abs(wheel_q[WHEEL_FR]) == {1'b0, limit_q}) ||
      (speed_abs(wheel_q[WHEEL_BL]) == {1'b0, limit_q}) ||
      (speed_abs(wheel_q[WHEEL_BR]) == {1'b0, limit_q}))
    else $error("scaled result has no wheel at the limit");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.ready |-> vo_q && !wheel_o.ready && v1_q && v2_q && v3_q)
    else $error("command refused while the pipeline has room");

endmodule

FILE: test/mecanum_wheel_mixer_tb.sv
module mecanum_wheel_mixer_tb;
  import mwm_pkg::*;

  localparam speed_t SPEED_MAX  = 16'sh7fff;
  localparam speed_t SPEED_MIN  = 16'sh8000;
  localparam lim_t   LIMIT_MAX  = 15'h7fff;

  typedef struct {
    speed_t wheel [LANES];
    logic   scaled;
  } wheel_set_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mwm_cfg_if   cfg_bus ();
  mwm_cmd_if   cmd_bus ();
  mwm_wheel_if wheel_bus ();

  mecanum_wheel_mixer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_bus),
    .cmd_i   (cmd_bus),
    .wheel_o (wheel_bus)
  );

  wheel_set_t expected_wheels [$];
  lim_t       speed_limit_now   = SPEED_LIMIT_RESET;
  int         cmd_gap_pct       = 0;
  int         wheel_stall_pct   = 0;
  int         wheel_hold_cycles = 0;
  int         mismatch_count    = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Wheel speeds for one command: full-width sums, then a common scale of
  // limit / peak, truncated towards zero, when the peak exceeds the limit.
  function automatic wheel_set_t mix_wheels(speed_t vx, speed_t vy, speed_t w, lim_t limit);
    sum_t       fwd;
    sum_t       side;
    sum_t       rot;
    sum_t       sums [LANES];
    mag_t       mags [LANES];
    mag_t       peak;
    prod_t      quo;
    wheel_set_t r;
    fwd  = vx;
    side = vy;
    rot  = w;
    sums[WHEEL_FL] = fwd - side - rot;
    sums[WHEEL_FR] = fwd + side + rot;
    sums[WHEEL_BL] = fwd + side - rot;
    sums[WHEEL_BR] = fwd - side + rot;
    peak = '0;
    for (int i = 0; i < LANES; i++) begin
      mags[i] = sums[i][SUM_W-1] ? mag_t'(-sums[i]) : mag_t'(sums[i]);
      if (mags[i] > peak) peak = mags[i];
    end
    r.scaled = (peak > limit);
    for (int i = 0; i < LANES; i++) begin
      if (r.scaled) begin
        quo = (prod_t'(mags[i]) * prod_t'(limit)) / prod_t'(peak);
        r.wheel[i] = sums[i][SUM_W-1] ? speed_t'(-quo) : speed_t'(quo);
      end else begin
        r.wheel[i] = speed_t'(sums[i]);
      end
    end
    return r;
  endfunction

  task automatic compare_field(string field, integer want, integer got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : wheel_check
    wheel_set_t want;
    if (rst_ni && wheel_bus.valid && wheel_bus.ready) begin
      if (expected_wheels.size() == 0) begin
        mismatch_count++;
        $display("%0t: wheel transaction expected none, got %0d %0d %0d %0d scaled %0d",
                 $time, wheel_bus.wheel_front_left, wheel_bus.wheel_front_right,
                 wheel_bus.wheel_back_left, wheel_bus.wheel_back_right,
                 wheel_bus.was_scaled);
      end else begin
        want = expected_wheels.pop_front();
        compare_field("front left", want.wheel[WHEEL_FL], wheel_bus.wheel_front_left);
        compare_field("front right", want.wheel[WHEEL_FR], wheel_bus.wheel_front_right);
        compare_field("back left", want.wheel[WHEEL_BL], wheel_bus.wheel_back_left);
        compare_field("back right", want.wheel[WHEEL_BR], wheel_bus.wheel_back_right);
        compare_field("was_scaled", want.scaled, wheel_bus.was_scaled);
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    wheel_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (wheel_hold_cycles > 0) begin
        wheel_bus.ready <= 1'b0;
        wheel_hold_cycles--;
      end else begin
        wheel_bus.ready <= ($urandom_range(99) >= wheel_stall_pct);
      end
    end
  end

  // Valid stays high from one transaction to the next unless a gap is drawn.
  task automatic send_command(speed_t vx, speed_t vy, speed_t w);
    @(negedge clk_i);
    if ($urandom_range(99) < cmd_gap_pct) begin
      cmd_bus.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < cmd_gap_pct);
    end
    cmd_bus.valid        <= 1'b1;
    cmd_bus.vel_forward  <= vx;
    cmd_bus.vel_sideways <= vy;
    cmd_bus.vel_rotation <= w;
    do @(posedge clk_i); while (!cmd_bus.ready);
    expected_wheels.push_back(mix_wheels(vx, vy, w, speed_limit_now));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    cmd_bus.valid <= 1'b0;
    while (expected_wheels.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_speed_limit(lim_t value);
    wait_drained();
    @(negedge clk_i);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.speed_limit <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    speed_limit_now = value;
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Items are whole-range noise, small commands that stay within the limit,
  // or commands built from the field extremes, zero and noise.
  task automatic send_random_commands(int count);
    speed_t axis [3];
    int     span;
    int     mode;
    repeat (count) begin
      span = int'(speed_limit_now) / 3;
      mode = $urandom_range(2);
      for (int k = 0; k < 3; k++) begin
        case (mode)
          0: axis[k] = speed_t'($urandom);
          1: axis[k] = speed_t'(int'($urandom_range(2 * span)) - span);
          default: begin
            case ($urandom_range(3))
              0: axis[k] = SPEED_MIN;
              1: axis[k] = SPEED_MAX;
              2: axis[k] = '0;
              default: axis[k] = speed_t'($urandom);
            endcase
          end
        endcase
      end
      send_command(axis[0], axis[1], axis[2]);
    end
  endtask

  task automatic test_reset_limit();
    send_command(0, 0, 0);
    send_command(6144, 0, 0);
    send_command(6145, 0, 0);
    send_command(0, 1000, 0);
    send_command(0, 0, -1000);
    send_command(SPEED_MIN, SPEED_MIN, SPEED_MIN);
    send_command(SPEED_MAX, SPEED_MAX, SPEED_MAX);
    send_command(SPEED_MAX, SPEED_MIN, SPEED_MIN);
    send_command(SPEED_MIN, SPEED_MAX, SPEED_MAX);
    send_command(4096, -2048, 1024);
  endtask

  task automatic test_limit_extremes();
    set_speed_limit(1);
    send_command(1, 0, 0);
    send_command(3, 1, 1);
    send_command(SPEED_MIN, 0, 0);
    set_speed_limit(LIMIT_MAX);
    send_command(SPEED_MAX, 0, 0);
    send_command(SPEED_MAX, 1, 0);
    send_command(SPEED_MIN, 0, 0);
    send_command(0, SPEED_MIN, 0);
    // A zero limit forces every non-zero command to all-zero wheels.
    set_speed_limit(0);
    send_command(0, 0, 0);
    send_command(1, 0, 0);
    send_command(-5, 3, 2);
  endtask

  task automatic test_random_traffic();
    set_speed_limit(lim_t'($urandom_range(1, LIMIT_MAX)));
    cmd_gap_pct     = 0;
    wheel_stall_pct = 0;
    send_random_commands(85);
    set_speed_limit(LIMIT_MAX);
    cmd_gap_pct     = 48;
    wheel_stall_pct = 0;
    send_random_commands(85);
    set_speed_limit(lim_t'($urandom_range(1, 400)));
    cmd_gap_pct     = 0;
    wheel_stall_pct = 48;
    send_random_commands(85);
    set_speed_limit(lim_t'($urandom_range(1, LIMIT_MAX)));
    cmd_gap_pct     = 27;
    wheel_stall_pct = 27;
    send_random_commands(85);
  endtask

  // The receiver holds off far longer than the pipeline is deep, so the
  // block fills and must refuse further commands until it is released.
  task automatic test_output_backpressure();
    set_speed_limit(SPEED_LIMIT_RESET);
    cmd_gap_pct     = 0;
    wheel_stall_pct = 0;
    @(posedge clk_i);
    wheel_hold_cycles = 150;
    send_random_commands(60);
  endtask

  initial begin
    rst_ni               = 1'b0;
    cmd_bus.valid        = 1'b0;
    cmd_bus.vel_forward  = '0;
    cmd_bus.vel_sideways = '0;
    cmd_bus.vel_rotation = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.speed_limit  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_limit();
    test_limit_extremes();
    test_random_traffic();
    test_output_backpressure();

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("mecanum_wheel_mixer test passed");
    end else begin
      $display("mecanum_wheel_mixer test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("mecanum_wheel_mixer test failed");
    $finish;
  end

endmodule

FILE: mecanum_wheel_mixer.f
rtl/core/mwm_pkg.sv
rtl/core/mwm_cmd_if.sv
rtl/core/mwm_wheel_if.sv
rtl/core/mwm_cfg_if.sv
rtl/core/mwm_divider.sv
rtl/core/mecanum_wheel_mixer.sv
test/mecanum_wheel_mixer_tb.sv
